FILE: src/dde_pkg.sv
// ----------------------------------------------------------------------------
// dde_pkg
// Shared types and constants of the decimal digit emitter.
// ----------------------------------------------------------------------------
package dde_pkg;

    localparam int unsigned NUM_W     = 32;
    localparam int unsigned CHAR_W    = 6;
    localparam int unsigned DIGIT_W   = 4;
    // Quotient of a 32-bit value by ten fits in 29 bits.
    localparam int unsigned QUOT_W    = 29;
    localparam int unsigned PROD_W    = 64;
    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 32-bit v.
    localparam logic [NUM_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_digit_beat;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL,
        FS_SUB,
        FS_EMIT
    } t_front_state;

endpackage

FILE: src/dde_front.sv
// ----------------------------------------------------------------------------
// dde_front
// Accepts a number, splits it into decimal digits by repeated division by ten
// (a multiply step and a subtract step per digit) and pushes the digits, most significant first, into the digit queue.
// ----------------------------------------------------------------------------
module dde_front #(
    parameter int unsigned MAX_DIGITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [dde_pkg::NUM_W-1:0]       i_number,
    output logic                            o_push,
    output dde_pkg::t_digit_beat            o_beat,
    input  logic                            i_full
);
    import dde_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    t_front_state r_state, n_state;
    logic [NUM_W-1:0]   r_value, n_value;
    logic [QUOT_W-1:0]  r_quot, n_quot;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DIGIT_W-1:0] r_store [MAX_DIGITS];

    logic [PROD_W-1:0]  prod;
    logic [DIGIT_W-1:0] ten_q_low;
    logic [DIGIT_W-1:0] rem;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   cnt_dec;
    logic               wr_en;

    assign prod      = {{(PROD_W-NUM_W){1'b0}}, r_value} * {{(PROD_W-NUM_W){1'b0}}, RECIP_TEN};
    // Only the low bits of 10*q matter: the remainder is below ten.
    assign ten_q_low = {r_quot[0], 3'b000} + {r_quot[2:0], 1'b0};
    assign rem       = r_value[DIGIT_W-1:0] - ten_q_low;
    assign cnt_inc   = r_cnt + 1'b1;
    assign cnt_dec   = r_cnt - 1'b1;

    always_comb begin
        n_state = r_state;
        n_value = r_value;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        o_ready = 1'b0;
        o_push  = 1'b0;
        wr_en   = 1'b0;
        o_beat.digit = r_store[cnt_dec[IDX_W-1:0]];
        o_beat.last  = (r_cnt == CNT_W'(1));
        unique case (r_state)
            FS_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_value = i_number;
                    n_cnt   = '0;
                    n_state = FS_MUL;
                end
            end
            FS_MUL: begin
                n_quot  = prod[RECIP_SHIFT +: QUOT_W];
                n_state = FS_SUB;
            end
            FS_SUB: begin
                // Zero input yields one digit '0' and stops here too.
                wr_en   = 1'b1;
                n_value = NUM_W'(r_quot);
                n_cnt   = cnt_inc;
                if (r_quot == '0 || cnt_inc == CNT_W'(MAX_DIGITS)) begin
                    n_state = FS_EMIT;
                end else begin
                    n_state = FS_MUL;
                end
            end
            FS_EMIT: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    n_cnt  = cnt_dec;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = FS_IDLE;
                    end
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_quot  <= n_quot;
        if (wr_en) begin
            r_store[r_cnt[IDX_W-1:0]] <= rem;
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == FS_MUL && r_cnt == '0))
        else $error("accepted number did not start a conversion");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_EMIT) |-> (r_cnt != '0))
        else $error("emit phase with no digits left");
    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_SUB) |-> (r_cnt < CNT_W'(MAX_DIGITS)))
        else $error("digit store overrun");
`endif

endmodule

FILE: src/dde_fifo.sv
// ----------------------------------------------------------------------------
// dde_fifo
// Short queue of digit beats between the converter and the output stage.
// ----------------------------------------------------------------------------
module dde_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dde_pkg::t_digit_beat  i_beat,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output dde_pkg::t_digit_beat  o_beat
);
    import dde_pkg::*;

    t_digit_beat           r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full digit queue");
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FIFO_CNT_W'(FIFO_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

FILE: src/dde_back.sv
// ----------------------------------------------------------------------------
// dde_back
// Output register: turns a digit into its ASCII code and holds the beat
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module dde_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  dde_pkg::t_digit_beat          i_beat,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dde_pkg::CHAR_W-1:0]    o_char,
    output logic                          o_last
);
    import dde_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char <= ASCII_ZERO + CHAR_W'(i_beat.digit);
            r_last <= i_beat.last;
        end
    end

endmodule

FILE: src/decimal_digit_emitter.sv
// A number is split into digits by the front stage, a multiply step and a
// subtract step per digit, then one digit per cycle enters the queue while
// the queue is not full; each digit passes the queue and the output register
// before its character beat is offered. The front stage takes a new number
// only after it has pushed every digit of the last one. Synchronous
// active-low reset empties all stages.
// ----------------------------------------------------------------------------
// decimal_digit_emitter
// Renders an unsigned 32-bit number as ASCII decimal digits, most
// significant first, with leading zeros suppressed and tlast on the final digit.
// ----------------------------------------------------------------------------
module decimal_digit_emitter #(
    parameter int unsigned MAX_DIGITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] char_code, [7:6] zero
    output logic        m_tlast    // last_digit
);
    import dde_pkg::*;

    logic              front_push;
    t_digit_beat       front_beat;
    logic              fifo_full;
    logic              fifo_valid;
    t_digit_beat       fifo_beat;
    logic              back_pop;
    logic [CHAR_W-1:0] back_char;

    dde_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_number (s_tdata),
        .o_push   (front_push),
        .o_beat   (front_beat),
        .i_full   (fifo_full)
    );

    dde_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_beat  (front_beat),
        .o_full  (fifo_full),
        .i_pop   (back_pop),
        .o_valid (fifo_valid),
        .o_beat  (fifo_beat)
    );

    dde_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fifo_valid),
        .i_beat  (fifo_beat),
        .o_pop   (back_pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_char  (back_char),
        .o_last  (m_tlast)
    );

    assign m_tdata = {2'b00, back_char};

endmodule
